// ----- sv/rpa_pkg.sv -----
// Shared types and constants for the reference-counted page allocator.
package rpa_pkg;

	localparam int NUM_PAGES = 32768;
	localparam int PAGE_W    = $clog2(NUM_PAGES);
	localparam int DEPTH_W   = PAGE_W + 1;
	localparam int CNT_W     = 8;
	localparam int IN_W      = 24;
	localparam int OUT_W     = 32;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [2:0] {
		OP_INIT      = 3'd0,
		OP_ALLOC     = 3'd1,
		OP_FREE      = 3'd2,
		OP_SHARE     = 3'd3,
		OP_COW_BEGIN = 3'd4,
		OP_COW_END   = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_PAGES  = 3'd1,
		ST_BAD_PAGE  = 3'd2,
		ST_NOT_ALLOC = 3'd3,
		ST_OVERFLOW  = 3'd4,
		ST_SOLE      = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_FILL
	} state_t;

	typedef struct packed {
		logic              cnt_we;
		logic [PAGE_W-1:0] cnt_waddr;
		logic [CNT_W-1:0]  cnt_wdata;
		logic [PAGE_W-1:0] cnt_raddr;
		logic              stk_we;
		logic [PAGE_W-1:0] stk_waddr;
		logic [PAGE_W-1:0] stk_wdata;
		logic [PAGE_W-1:0] stk_raddr;
	} mem_req_t;

endpackage

// ----- sv/rpa_store.sv -----
// Count and free-stack memories, one write and one registered read each per cycle.
module rpa_store (
	input  logic                              clk,
	input  rpa_pkg::mem_req_t                 req,
	output logic [rpa_pkg::CNT_W-1:0]         cnt_rdata_s1,
	output logic [rpa_pkg::PAGE_W-1:0]        stk_rdata_s1
);
	import rpa_pkg::*;

	logic [CNT_W-1:0]  cnt_mem [NUM_PAGES];
	logic [PAGE_W-1:0] stk_mem [NUM_PAGES];

	always_ff @(posedge clk) begin
		if (req.cnt_we) begin
			cnt_mem[req.cnt_waddr] <= req.cnt_wdata;
		end
		cnt_rdata_s1 <= cnt_mem[req.cnt_raddr];
	end

	always_ff @(posedge clk) begin
		if (req.stk_we) begin
			stk_mem[req.stk_waddr] <= req.stk_wdata;
		end
		stk_rdata_s1 <= stk_mem[req.stk_raddr];
	end

endmodule

// ----- sv/refcounted_page_allocator.sv -----
// Top level: page allocator with per-page reference counts and a LIFO free stack.
//
//  channel  dir  beat moves                   accepted when
//  s_*      in   one operation                s_tvalid & s_tready
//  m_*      out  one result                   m_tvalid & m_tready
//  cfg_*    in   first_page register          cfg_we
//
// Every operation but init reads the count and stack-top entries, then decides and
// writes back. Init sweeps all NUM_PAGES count entries (and the stack entries from
// first_page up), one per cycle, then answers. After reset a clearing pass zeroes
// all NUM_PAGES counts; s_tready is low during it. A new operation is taken while a
// result waits on m_*; the write-back of that operation holds until the output
// register frees up.
module refcounted_page_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rpa_pkg::PAGE_W-1:0]    cfg_wdata,  // first_page
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [rpa_pkg::IN_W-1:0]      s_tdata,    // op[2:0], page[17:3], succeeded[18]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [rpa_pkg::OUT_W-1:0]     m_tdata     // status[2:0], new_page[17:3],
	                                                   // page_released[18], ref_count[26:19]
);
	import rpa_pkg::*;

	localparam logic [PAGE_W-1:0]  LAST_PAGE = PAGE_W'(NUM_PAGES - 1);
	localparam logic [DEPTH_W-1:0] FULL      = DEPTH_W'(NUM_PAGES);

	state_t             state_q, state_d;
	logic [PAGE_W-1:0]  first_q;
	logic [DEPTH_W-1:0] depth_q, depth_d;
	logic [PAGE_W-1:0]  swp_q, swp_d;

	op_t                op_q;
	logic [PAGE_W-1:0]  page_q;
	logic               succ_q;

	logic               out_valid_q;
	status_t            out_status_q;
	logic [PAGE_W-1:0]  out_page_q;
	logic               out_rel_q;
	logic [CNT_W-1:0]   out_cnt_q;

	status_t            res_status;
	logic [PAGE_W-1:0]  res_page;
	logic               res_rel;
	logic [CNT_W-1:0]   res_cnt;
	logic               load;

	mem_req_t           req;
	logic [CNT_W-1:0]   cnt_rdata_s1;
	logic [PAGE_W-1:0]  stk_rdata_s1;

	logic               accept;
	logic               slot_free;
	logic               managed;
	logic               last_swp;
	logic [PAGE_W-1:0]  s_page;
	logic [CNT_W-1:0]   c;

	rpa_store u_store (
		.clk          (clk),
		.req          (req),
		.cnt_rdata_s1 (cnt_rdata_s1),
		.stk_rdata_s1 (stk_rdata_s1)
	);

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid & s_tready;
	assign s_page    = s_tdata[3 +: PAGE_W];
	assign slot_free = !out_valid_q || m_tready;
	assign last_swp  = (swp_q == LAST_PAGE);
	assign c         = cnt_rdata_s1;
	assign managed   = (page_q >= first_q) && ({1'b0, page_q} < FULL);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_cnt_q, out_rel_q, out_page_q, out_status_q};

	always_comb begin
		state_d       = state_q;
		depth_d       = depth_q;
		swp_d         = swp_q;
		load          = 1'b0;
		res_status    = ST_OK;
		res_page      = '0;
		res_rel       = 1'b0;
		res_cnt       = '0;
		req           = '0;
		req.cnt_raddr = (state_q == S_IDLE) ? s_page : page_q;
		req.stk_raddr = PAGE_W'(depth_q - 1'b1);

		case (state_q)
			S_CLEAR: begin
				req.cnt_we    = 1'b1;
				req.cnt_waddr = swp_q;
				swp_d         = swp_q + 1'b1;
				if (last_swp) begin
					state_d = S_IDLE;
				end
			end
			S_FILL: begin
				req.cnt_we    = 1'b1;
				req.cnt_waddr = swp_q;
				req.stk_we    = (swp_q >= first_q);
				req.stk_waddr = swp_q - first_q;
				req.stk_wdata = swp_q;
				swp_d         = swp_q + 1'b1;
				if (last_swp) begin
					depth_d = FULL - {1'b0, first_q};
					state_d = S_EXEC;
				end
			end
			S_IDLE: begin
				if (accept) begin
					swp_d   = '0;
					state_d = (op_t'(s_tdata[2:0]) == OP_INIT) ? S_FILL : S_EXEC;
				end
			end
			S_EXEC: begin
				if (slot_free) begin
					load    = 1'b1;
					state_d = S_IDLE;
					case (op_q)
						OP_ALLOC: begin
							if (depth_q == '0) begin
								res_status = ST_NO_PAGES;
							end else begin
								depth_d       = depth_q - 1'b1;
								req.cnt_we    = 1'b1;
								req.cnt_waddr = stk_rdata_s1;
								req.cnt_wdata = CNT_W'(1);
								res_page      = stk_rdata_s1;
								res_cnt       = CNT_W'(1);
							end
						end
						OP_FREE, OP_SHARE, OP_COW_BEGIN, OP_COW_END: begin
							if (!managed) begin
								res_status = ST_BAD_PAGE;
							end else begin
								res_cnt = c;
								if (c == '0) begin
									res_status = ST_NOT_ALLOC;
								end else begin
									case (op_q)
										OP_FREE: begin
											req.cnt_we    = 1'b1;
											req.cnt_waddr = page_q;
											req.cnt_wdata = c - 1'b1;
											res_cnt       = c - 1'b1;
											// last reference gone: push unless stack full
											if (c == CNT_W'(1) && depth_q < FULL) begin
												req.stk_we    = 1'b1;
												req.stk_waddr = depth_q[PAGE_W-1:0];
												req.stk_wdata = page_q;
												depth_d       = depth_q + 1'b1;
												res_rel       = 1'b1;
											end
										end
										OP_SHARE: begin
											if (c == CNT_MAX) begin
												res_status = ST_OVERFLOW;
											end else begin
												req.cnt_we    = 1'b1;
												req.cnt_waddr = page_q;
												req.cnt_wdata = c + 1'b1;
												res_cnt       = c + 1'b1;
											end
										end
										OP_COW_BEGIN: begin
											if (c == CNT_W'(1)) begin
												res_status = ST_SOLE;
											end else if (depth_q == '0) begin
												res_status = ST_NO_PAGES;
											end else begin
												depth_d       = depth_q - 1'b1;
												req.cnt_we    = 1'b1;
												req.cnt_waddr = stk_rdata_s1;
												req.cnt_wdata = CNT_W'(1);
												res_page      = stk_rdata_s1;
												res_cnt       = CNT_W'(1);
											end
										end
										default: begin
											if (succ_q && c > CNT_W'(1)) begin
												req.cnt_we    = 1'b1;
												req.cnt_waddr = page_q;
												req.cnt_wdata = c - 1'b1;
												res_cnt       = c - 1'b1;
											end
										end
									endcase
								end
							end
						end
						default: begin
							// init answer after its sweep, and unused codes
						end
					endcase
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			swp_q   <= '0;
			depth_q <= '0;
			first_q <= '0;
		end else begin
			state_q <= state_d;
			swp_q   <= swp_d;
			depth_q <= depth_d;
			if (cfg_we) begin
				first_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(s_tdata[2:0]);
			page_q <= s_page;
			succ_q <= s_tdata[3 + PAGE_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q <= res_status;
			out_page_q   <= res_page;
			out_rel_q    <= res_rel;
			out_cnt_q    <= res_cnt;
		end
	end

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= FULL)
		else $error("stack depth above page count");

	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC || state_q == S_FILL))
		else $error("accepted beat not executed");

	a_depth_source: assert property (@(posedge clk) disable iff (!arst_n)
		(depth_q != $past(depth_q)) |->
			($past(state_q) == S_EXEC || $past(state_q) == S_FILL))
		else $error("stack depth changed outside execute or fill");

	a_load_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !req.cnt_we || state_q != S_EXEC)
		else $error("write-back while result still pending");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_EXEC)
		else $error("result loaded outside execute");

endmodule

// ----- verif/refcounted_page_allocator_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for refcounted_page_allocator: directed and random ops, predicted results.
module refcounted_page_allocator_tb;
	import rpa_pkg::*;

	localparam logic [2:0] OP_RSVD_A = 3'd6;
	localparam logic [2:0] OP_RSVD_B = 3'd7;
	localparam int TOP_PAGE = NUM_PAGES - 1;
	// init and the power-up clear each sweep all NUM_PAGES entries with no beat
	localparam int QUIET_LIMIT = 5 * NUM_PAGES;
	localparam int MAX_PRINTS = 40;

	typedef struct {
		logic [2:0]        op;
		logic [PAGE_W-1:0] page;
		logic              succeeded;
	} page_op_t;

	typedef struct {
		status_t           status;
		logic [PAGE_W-1:0] new_page;
		logic              released;
		logic [CNT_W-1:0]  ref_count;
	} page_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [PAGE_W-1:0] cfg_wdata = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;

	// predictor copy of the allocator
	logic [CNT_W-1:0]  ref_counts [NUM_PAGES] = '{default: '0};
	logic [PAGE_W-1:0] free_pages [NUM_PAGES];
	int                free_depth = 0;
	logic [PAGE_W-1:0] base_page = '0;

	page_op_t     op_backlog[$];
	page_result_t pending_results[$];
	page_op_t     cur_op;
	logic         op_taken = 1'b0;

	int n_queued = 0;
	int n_issued = 0;
	int n_checked = 0;
	int n_errors = 0;
	int n_settings = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int status_seen [8] = '{default: 0};

	refcounted_page_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	function automatic page_result_t apply_page_op(page_op_t item);
		page_result_t r;
		logic [CNT_W-1:0] c;
		int p;
		r.status = ST_OK;
		r.new_page = '0;
		r.released = 1'b0;
		r.ref_count = '0;
		case (item.op)
		OP_INIT: begin
			for (p = 0; p < NUM_PAGES; p++)
				ref_counts[p] = '0;
			free_depth = 0;
			for (p = int'(base_page); p < NUM_PAGES; p++) begin
				free_pages[free_depth] = p[PAGE_W-1:0];
				free_depth++;
			end
		end
		OP_ALLOC: begin
			if (free_depth == 0) begin
				r.status = ST_NO_PAGES;
			end else begin
				free_depth--;
				r.new_page = free_pages[free_depth];
				ref_counts[r.new_page] = CNT_W'(1);
				r.ref_count = CNT_W'(1);
			end
		end
		OP_FREE, OP_SHARE, OP_COW_BEGIN, OP_COW_END: begin
			c = ref_counts[item.page];
			if (item.page < base_page) begin
				r.status = ST_BAD_PAGE;
			end else if (c == 0) begin
				r.status = ST_NOT_ALLOC;
			end else begin
				r.ref_count = c;
				case (item.op)
				OP_FREE: begin
					c = c - 1'b1;
					ref_counts[item.page] = c;
					r.ref_count = c;
					if (c == 0 && free_depth < NUM_PAGES) begin
						free_pages[free_depth] = item.page;
						free_depth++;
						r.released = 1'b1;
					end
				end
				OP_SHARE: begin
					if (c == CNT_MAX) begin
						r.status = ST_OVERFLOW;
					end else begin
						ref_counts[item.page] = c + 1'b1;
						r.ref_count = c + 1'b1;
					end
				end
				OP_COW_BEGIN: begin
					if (c == 1) begin
						r.status = ST_SOLE;
					end else if (free_depth == 0) begin
						r.status = ST_NO_PAGES;
					end else begin
						free_depth--;
						r.new_page = free_pages[free_depth];
						ref_counts[r.new_page] = CNT_W'(1);
						r.ref_count = CNT_W'(1);
					end
				end
				OP_COW_END: begin
					if (item.succeeded && c > 1) begin
						ref_counts[item.page] = c - 1'b1;
						r.ref_count = c - 1'b1;
					end
				end
				default: ;
				endcase
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		n_errors++;
		if (n_errors <= MAX_PRINTS)
			$display("MISMATCH %s at result %0d: got 0x%0h, expected 0x%0h",
				what, n_checked, got, want);
	endtask

	// op side: accept at the rising edge, drive at the falling edge
	always @(posedge clk) begin
		op_taken = arst_n && s_tvalid && s_tready;
		if (op_taken) begin
			pending_results.push_back(apply_page_op(cur_op));
			n_issued++;
		end
		if (arst_n && cfg_we)
			base_page = cfg_wdata;
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || op_taken) begin
			if (op_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				cur_op = op_backlog.pop_front();
				s_tdata <= {5'b0, cur_op.succeeded, cur_op.page, cur_op.op};
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result side
	always @(negedge clk)
		m_tready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);

	always @(posedge clk) begin
		page_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			n_checked++;
			status_seen[m_tdata[2:0]]++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected beat", m_tdata, '0);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[2:0] !== want.status)
					report_mismatch("status", 32'(m_tdata[2:0]), 32'(want.status));
				if (m_tdata[17:3] !== want.new_page)
					report_mismatch("new_page", 32'(m_tdata[17:3]), 32'(want.new_page));
				if (m_tdata[18] !== want.released)
					report_mismatch("page_released", 32'(m_tdata[18]), 32'(want.released));
				if (m_tdata[26:19] !== want.ref_count)
					report_mismatch("ref_count", 32'(m_tdata[26:19]), 32'(want.ref_count));
				if (m_tdata[OUT_W-1:27] !== '0)
					report_mismatch("pad bits", 32'(m_tdata[OUT_W-1:27]), '0);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no beat for %0d cycles, %0d results outstanding",
				quiet_cycles, pending_results.size());
			$display("refcounted_page_allocator regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_op(logic [2:0] op, int page, int succ);
		page_op_t item;
		item.op = op;
		item.page = page[PAGE_W-1:0];
		item.succeeded = succ[0];
		op_backlog.push_back(item);
		n_queued++;
	endtask

	task automatic wait_idle();
		while (n_issued != n_queued || pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_first_page(int value);
		@(negedge clk);
		cfg_wdata <= value[PAGE_W-1:0];
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// allocations pop from the top of the index range, so live pages sit at and just below TOP_PAGE
	task automatic gen_random_op(int win);
		int roll;
		int pg;
		int sc;
		roll = $urandom_range(0, 99);
		sc = $urandom_range(0, 1);
		pg = TOP_PAGE - $urandom_range(0, win);
		if (roll < 4)
			push_op($urandom_range(0, 1) ? OP_RSVD_A : OP_RSVD_B, $urandom_range(0, TOP_PAGE), sc);
		else if (roll < 10)
			push_op(3'($urandom_range(OP_FREE, OP_COW_END)), $urandom_range(0, TOP_PAGE), sc);
		else if (roll < 35)
			push_op(OP_ALLOC, $urandom_range(0, TOP_PAGE), sc);
		else if (roll < 55)
			push_op(OP_FREE, pg, sc);
		else if (roll < 75)
			push_op(OP_SHARE, pg, sc);
		else if (roll < 88) begin
			push_op(OP_COW_BEGIN, pg, sc);
			push_op(OP_COW_END, pg, int'($urandom_range(0, 3) != 0));
		end else
			push_op(OP_COW_END, pg, sc);
	endtask

	task automatic run_phase(int fp, int n_ops, bit pump);
		int start;
		int win;
		bit mid_init;
		wait_idle();
		write_first_page(fp);
		win = (TOP_PAGE - fp < 64) ? TOP_PAGE - fp : 64;
		mid_init = 1'b0;
		push_op(OP_INIT, $urandom_range(0, TOP_PAGE), $urandom_range(0, 1));
		if (pump) begin
			// drive the top page's count into saturation
			push_op(OP_ALLOC, 0, 0);
			repeat (256)
				push_op(OP_SHARE, TOP_PAGE, $urandom_range(0, 1));
		end
		start = n_queued;
		while (n_queued - start < n_ops) begin
			if (!mid_init && n_queued - start >= n_ops / 2) begin
				push_op(OP_INIT, $urandom_range(0, TOP_PAGE), $urandom_range(0, 1));
				mid_init = 1'b1;
			end
			gen_random_op(win);
		end
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 15;
		recv_idle_pct = 46;

		// three managed pages: exercise every op and every error path but overflow by hand
		write_first_page(TOP_PAGE - 2);
		push_op(OP_INIT, TOP_PAGE, 1);
		push_op(OP_RSVD_A, $urandom_range(0, TOP_PAGE), 0);
		push_op(OP_RSVD_B, TOP_PAGE, 1);
		push_op(OP_FREE, 0, 0);
		push_op(OP_SHARE, TOP_PAGE - 3, 1);
		push_op(OP_COW_BEGIN, 0, 1);
		push_op(OP_COW_END, TOP_PAGE - 3, 1);
		push_op(OP_SHARE, TOP_PAGE, 0);
		push_op(OP_FREE, TOP_PAGE, 0);
		push_op(OP_COW_BEGIN, TOP_PAGE - 1, 0);
		push_op(OP_COW_END, TOP_PAGE, 1);
		push_op(OP_ALLOC, 0, 0);
		push_op(OP_ALLOC, TOP_PAGE, 1);
		push_op(OP_ALLOC, 0, 0);
		push_op(OP_ALLOC, 0, 0);           // pool empty
		push_op(OP_COW_BEGIN, TOP_PAGE, 0); // sole owner
		push_op(OP_SHARE, TOP_PAGE, 0);
		push_op(OP_COW_BEGIN, TOP_PAGE, 0); // needs a page, none left
		push_op(OP_FREE, TOP_PAGE - 1, 0);
		push_op(OP_COW_BEGIN, TOP_PAGE, 0);
		push_op(OP_COW_END, TOP_PAGE, 0);
		push_op(OP_COW_END, TOP_PAGE, 1);
		push_op(OP_COW_END, TOP_PAGE, 1);
		push_op(OP_FREE, TOP_PAGE, 1);
		push_op(OP_INIT, 0, 0);

		run_phase(0, 120, 1'b1);
		run_phase(TOP_PAGE, 90, 1'b0);

		wait_idle();
		send_idle_pct = 46;
		recv_idle_pct = 15;
		run_phase(TOP_PAGE - 7, 200, 1'b0);
		run_phase($urandom_range(1, TOP_PAGE - 1), 160, 1'b0);

		wait_idle();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(TOP_PAGE - 27, 200, 1'b0);

		wait_idle();
		repeat (40) @(posedge clk);

		$display("%0d ops over %0d first_page settings, %0d results checked, %0d mismatches",
			n_issued, n_settings, n_checked, n_errors);
		$display("status mix: ok %0d, no pages %0d, bad page %0d, unallocated %0d, %s %0d, %s %0d",
			status_seen[ST_OK], status_seen[ST_NO_PAGES], status_seen[ST_BAD_PAGE],
			status_seen[ST_NOT_ALLOC], "overflow", status_seen[ST_OVERFLOW],
			"sole owner", status_seen[ST_SOLE]);
		if (n_errors == 0)
			$display("refcounted_page_allocator regression: pass");
		else
			$display("refcounted_page_allocator regression: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/rpa_pkg.sv
sv/rpa_store.sv
sv/refcounted_page_allocator.sv
verif/refcounted_page_allocator_tb.sv
